// ===== design/fwsm_pkg.sv =====
// package for the first window strict minimum block
// widths, config register indexes and the judge result type; no dependencies
package fwsm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 17;
  localparam int WIN_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_BEFORE = 7;
  localparam int DEF_MAX_AFTER  = 7;
  localparam int DEF_MAX_LENGTH = 65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BEFORE_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AFTER_WINDOW  = 1'b1;

  // outcome of judging the candidates for one item
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
  } judge_t;

endpackage

// ===== design/fwsm_judge.sv =====
// candidate judge: window compares over the updated history, then selection
// depends on fwsm_pkg
module fwsm_judge #(
  parameter int MAX_BEFORE = fwsm_pkg::DEF_MAX_BEFORE,
  parameter int MAX_AFTER  = fwsm_pkg::DEF_MAX_AFTER,
  parameter int CNT_W      = 17
) (
  input  logic [MAX_BEFORE+MAX_AFTER:0][fwsm_pkg::SAMPLE_W-1:0] hist,
  input  logic [MAX_BEFORE+MAX_AFTER:0]                         hist_valid,
  input  logic [CNT_W-1:0]                                      count,
  input  logic [fwsm_pkg::WIN_W-1:0]                            bw,
  input  logic [fwsm_pkg::WIN_W-1:0]                            aw,
  input  logic                                                  last,
  output fwsm_pkg::judge_t                                      res
);
  import fwsm_pkg::*;

  localparam int DW = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [MAX_AFTER:0] qual;

  // each candidate offset against its left and right windows
  always_comb begin
    for (int k = 0; k <= MAX_AFTER; k++) begin
      qual[k] = hist_valid[k];
      for (int j = 1; j <= MAX_BEFORE; j++) begin
        if (j <= int'(bw) && hist_valid[k+j] && (hist[k+j] <= hist[k])) begin
          qual[k] = 1'b0;
        end
      end
      for (int j = 1; j <= k; j++) begin
        if (j <= int'(aw) && (hist[k-j] <= hist[k])) begin
          qual[k] = 1'b0;
        end
      end
    end
  end

  // final item: oldest pending candidate wins; otherwise only offset aw
  always_comb begin
    logic [DW-1:0] diff;
    res  = '0;
    diff = '0;
    for (int k = 0; k <= MAX_AFTER; k++) begin
      if (qual[k] && ((last && k <= int'(aw)) || (!last && k == int'(aw)))) begin
        res.hit = 1'b1;
        diff    = DW'(count) - DW'(k);
      end
    end
    res.position = diff[POS_W-1:0];
  end

endmodule

// ===== design/first_window_strict_minimum_core.sv =====
// top level of the first window strict minimum block
// history, counters, config and result register; uses fwsm_pkg and fwsm_judge
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+-----------------------
//  input   | in_sample, in_last_sample           | in_valid / in_ready
//  result  | out_found, out_position             | out_valid / out_ready
//  config  | cfg_index, cfg_wdata                | cfg_we, no wait
//
// one item per cycle while in_ready is high; a result appears in the cycle after
// its item is accepted, set by the single result register behind the window compares.
// in_ready is high whenever the result register is empty or being taken.
// rst_n is synchronous, active low, and clears history valid bits, count,
// answered flag, result valid and both window registers.
module first_window_strict_minimum_core #(
  parameter int MAX_BEFORE = fwsm_pkg::DEF_MAX_BEFORE,
  parameter int MAX_AFTER  = fwsm_pkg::DEF_MAX_AFTER,
  parameter int MAX_LENGTH = fwsm_pkg::DEF_MAX_LENGTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fwsm_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [fwsm_pkg::POS_W-1:0]      out_position,
  input  logic                            cfg_we,
  input  logic [fwsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fwsm_pkg::WIN_W-1:0]      cfg_wdata
);
  import fwsm_pkg::*;

  localparam int DEPTH = MAX_BEFORE + MAX_AFTER + 1;
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);

  logic [WIN_W-1:0] before_window_r, after_window_r;
  logic [WIN_W-1:0] bw, aw;

  logic [DEPTH-1:0][SAMPLE_W-1:0] hist_r, hist_nxt;
  logic [DEPTH-1:0]               hist_valid_r, hist_valid_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           answered_r, answered_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_position_r, out_position_nxt;

  logic   in_acc, room;
  judge_t jres;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign room     = count_r < CNT_W'(MAX_LENGTH);

  // window registers; their values are clamped to MAX_BEFORE and MAX_AFTER
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_window_r <= '0;
      after_window_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BEFORE_WINDOW: before_window_r <= cfg_wdata;
        CFG_AFTER_WINDOW:  after_window_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign bw = (int'(before_window_r) > MAX_BEFORE) ? WIN_W'(MAX_BEFORE) : before_window_r;
  assign aw = (int'(after_window_r) > MAX_AFTER) ? WIN_W'(MAX_AFTER) : after_window_r;

  // history view after this item: shifted in unless the count is saturated
  always_comb begin
    if (room) begin
      hist_nxt       = {hist_r[DEPTH-2:0], in_sample};
      hist_valid_nxt = {hist_valid_r[DEPTH-2:0], 1'b1};
      count_nxt      = count_r + 1'b1;
    end else begin
      hist_nxt       = hist_r;
      hist_valid_nxt = hist_valid_r;
      count_nxt      = count_r;
    end
  end

  fwsm_judge #(
    .MAX_BEFORE (MAX_BEFORE),
    .MAX_AFTER  (MAX_AFTER),
    .CNT_W      (CNT_W)
  ) u_judge (
    .hist       (hist_nxt),
    .hist_valid (hist_valid_nxt),
    .count      (count_nxt),
    .bw         (bw),
    .aw         (aw),
    .last       (in_last_sample),
    .res        (jres)
  );

  // result and answered flag for the accepted item
  always_comb begin
    answered_nxt     = answered_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    if (in_acc && !answered_r) begin
      if (in_last_sample) begin
        out_valid_nxt    = 1'b1;
        out_found_nxt    = jres.hit;
        out_position_nxt = jres.hit ? jres.position : '0;
      end else if (room && jres.hit) begin
        out_valid_nxt    = 1'b1;
        out_found_nxt    = 1'b1;
        out_position_nxt = jres.position;
        answered_nxt     = 1'b1;
      end
    end
  end

  // sequence state, cleared after the final item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= '0;
      count_r      <= '0;
      answered_r   <= 1'b0;
    end else if (in_acc) begin
      if (in_last_sample) begin
        hist_valid_r <= '0;
        count_r      <= '0;
        answered_r   <= 1'b0;
      end else begin
        hist_valid_r <= hist_valid_nxt;
        count_r      <= count_nxt;
        answered_r   <= answered_nxt;
      end
    end
  end

  // sample payload, written on each accepted item; qualified by the valid bits
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist_r <= hist_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule
